// ===== rtl/core/slip_pkg.sv =====
`timescale 1ns / 1ps

package slip_pkg;

  // SLIP special characters
  localparam logic [7:0] END_CODE     = 8'hC0;
  localparam logic [7:0] ESC_CODE     = 8'hDB;
  localparam logic [7:0] ESC_END_CODE = 8'hDC;
  localparam logic [7:0] ESC_ESC_CODE = 8'hDD;

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // most result bytes one item can cause
  localparam int MAX_RESULTS = 4;

  typedef enum logic [1:0] {
    CMD_DECODE = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_EMPTY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BAD_ESC = 2'd1,
    ERR_ESC_END = 2'd2
  } err_t;

  // one classified item: up to four results that share their flags
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0]       bytes;
    logic [$clog2(MAX_RESULTS)-1:0]    last_idx;
    logic                              has_byte;
    logic                              packet_end;
    err_t                              error_code;
  } job_t;

endpackage

// ===== rtl/core/slip_req_if.sv =====
`timescale 1ns / 1ps

interface slip_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source(output valid, output cmd, output data_byte, output first_of_packet,
                 output last_of_packet, input ready);
  modport sink(input valid, input cmd, input data_byte, input first_of_packet,
               input last_of_packet, output ready);
endinterface

// ===== rtl/core/slip_res_if.sv =====
`timescale 1ns / 1ps

interface slip_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       packet_end;
  logic [1:0] error_code;
  logic       last_result;

  modport source(output valid, output out_byte, output has_byte, output packet_end,
                 output error_code, output last_result, input ready);
  modport sink(input valid, input out_byte, input has_byte, input packet_end,
               input error_code, input last_result, output ready);
endinterface

// ===== rtl/core/slip_byte_stream_codec.sv =====
// An accepted item is written into the job queue; its first result is then loaded from
// the queue head into the output register, where result.valid shows it.
// Throughput: one result per cycle from the output register while the queue holds jobs
// and result.ready is high; an item has 1 to 4 results, and one with none is not queued.
// A job queue (QueueDepth entries) lets input accept run ahead of the output.
// Reset clears the escape flag, empties the queue and the output register.
`timescale 1ns / 1ps

module slip_byte_stream_codec #(
  parameter int QueueDepth = slip_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  slip_req_if.sink   request,
  slip_res_if.source result
);

  slip_pkg::job_t push_job;
  slip_pkg::job_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  // classify items and track the escape flag
  slip_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .full    (full),
    .push    (push),
    .job     (push_job)
  );

  // decouple classification from output
  slip_job_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // emit results one per cycle while result.ready is high
  slip_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== rtl/core/slip_front.sv =====
`timescale 1ns / 1ps

module slip_front (
  input  logic           clk,
  input  logic           rst,
  slip_req_if.sink       request,
  input  logic           full,
  output logic           push,
  output slip_pkg::job_t job
);

  logic       escape_pending;
  logic       escape_pending_next;
  logic       accept;
  logic [2:0] count;

  assign request.ready = !full;
  assign accept        = request.valid && !full;

  // classify the item into a list of results
  always_comb begin
    job                 = '0;
    count               = 3'd0;
    escape_pending_next = escape_pending;
    if (request.cmd == slip_pkg::CMD_DECODE) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        count               = 3'd1;
        if (request.data_byte == slip_pkg::END_CODE) begin
          job.packet_end = 1'b1;
          job.error_code = slip_pkg::ERR_ESC_END;
        end else if (request.data_byte == slip_pkg::ESC_END_CODE) begin
          job.bytes[0] = slip_pkg::END_CODE;
          job.has_byte = 1'b1;
        end else if (request.data_byte == slip_pkg::ESC_ESC_CODE) begin
          job.bytes[0] = slip_pkg::ESC_CODE;
          job.has_byte = 1'b1;
        end else begin
          job.bytes[0]   = slip_pkg::ESC_CODE;
          job.has_byte   = 1'b1;
          job.error_code = slip_pkg::ERR_BAD_ESC;
        end
      end else if (request.data_byte == slip_pkg::END_CODE) begin
        count          = 3'd1;
        job.packet_end = 1'b1;
      end else if (request.data_byte == slip_pkg::ESC_CODE) begin
        escape_pending_next = 1'b1;
      end else begin
        count        = 3'd1;
        job.bytes[0] = request.data_byte;
        job.has_byte = 1'b1;
      end
    end else if (request.cmd == slip_pkg::CMD_ENCODE) begin
      job.has_byte = 1'b1;
      if (request.first_of_packet) begin
        job.bytes[count[1:0]] = slip_pkg::END_CODE;
        count = count + 3'd1;
      end
      if (request.data_byte == slip_pkg::END_CODE) begin
        job.bytes[count[1:0]] = slip_pkg::ESC_CODE;
        count = count + 3'd1;
        job.bytes[count[1:0]] = slip_pkg::ESC_END_CODE;
        count = count + 3'd1;
      end else if (request.data_byte == slip_pkg::ESC_CODE) begin
        job.bytes[count[1:0]] = slip_pkg::ESC_CODE;
        count = count + 3'd1;
        job.bytes[count[1:0]] = slip_pkg::ESC_ESC_CODE;
        count = count + 3'd1;
      end else begin
        job.bytes[count[1:0]] = request.data_byte;
        count = count + 3'd1;
      end
      if (request.last_of_packet) begin
        job.bytes[count[1:0]] = slip_pkg::END_CODE;
        count = count + 3'd1;
      end
    end else if (request.cmd == slip_pkg::CMD_EMPTY) begin
      job.has_byte = 1'b1;
      job.bytes[0] = slip_pkg::END_CODE;
      job.bytes[1] = slip_pkg::END_CODE;
      count        = 3'd2;
    end
    job.last_idx = 2'(count - 3'd1);
  end

  // queue only items that cause results
  assign push = accept && (count != 3'd0);

  // hold the escape flag across items
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ===== rtl/core/slip_job_fifo.sv =====
`timescale 1ns / 1ps

module slip_job_fifo #(
  parameter int Depth = slip_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slip_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output slip_pkg::job_t head
);

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  slip_pkg::job_t          entries [Depth];
  logic [PtrW-1:0]         wr_ptr;
  logic [PtrW-1:0]         rd_ptr;
  logic [CountW-1:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count == CountW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/slip_back.sv =====
`timescale 1ns / 1ps

module slip_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  slip_pkg::job_t head,
  output logic           pop,
  slip_res_if.source     result
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       packet_end;
  logic [1:0] error_code;
  logic       last_result;
  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!out_valid || result.ready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  // step through the results of the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? '0 : idx + 2'd1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= head.bytes[idx];
      has_byte    <= head.has_byte;
      packet_end  <= head.packet_end;
      error_code  <= head.error_code;
      last_result <= at_last;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.has_byte    = has_byte;
  assign result.packet_end  = packet_end;
  assign result.error_code  = error_code;
  assign result.last_result = last_result;

endmodule
